// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sak assertion failed");
`define SAK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sak next-cycle assertion failed");
`else
`define SAK_ASSERT(lbl, clk, rst_n, prop)
`define SAK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/sak_pkg.sv =====
// shared types, constants and sequence helpers of the reliability tracker
package sak_pkg;

    localparam int unsigned PENDING_DEPTH_DEF = 64;
    localparam int unsigned RECV_DEPTH_DEF    = 64;
    localparam int unsigned WINDOW_BACK_DEF   = 34;
    localparam int unsigned MAX_ACKS          = 33;
    localparam int unsigned ACKW              = $clog2(MAX_ACKS + 1);

    localparam logic [15:0] SEQ_MAX_RST = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    // divide by ten: x * RTT_RECIP >> RTT_SHIFT is exact for x below 2^26
    localparam logic [24:0] RTT_RECIP = 25'd26843546;
    localparam int unsigned RTT_SHIFT = 28;
    localparam logic [24:0] RTT_ROUND = 25'd5;

    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_RECV = 2'd1;
    localparam logic [1:0] MODE_ACK  = 2'd2;
    localparam logic [1:0] MODE_TICK = 2'd3;

    localparam logic CFG_SEQ_MAX = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] rx_sequence;
        logic [15:0] ack_sequence;
        logic [31:0] ack_field;
        logic [15:0] delta_ticks;
    } t_in_item;

    typedef struct packed {
        logic [15:0] local_seq;
        logic [15:0] remote_seq;
        logic [31:0] ack_bits_out;
        logic [15:0] acked_seq;
        logic        acked_valid;
        logic        last;
        logic [31:0] sent_count;
        logic [31:0] recv_count;
        logic [31:0] lost_count;
        logic [31:0] acked_count;
        logic [23:0] rtt_avg;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [15:0] age;
    } t_rtt_req;

    typedef struct packed {
        logic        done;
        logic [23:0] rtt;
    } t_rtt_rsp;

    // a is more recent than b under wrapping
    function automatic logic newer(input logic [15:0] a, input logic [15:0] b,
                                   input logic [15:0] smax);
        logic [15:0] half;
        half = smax >> 1;
        return ((a > b) && ((a - b) <= half)) || ((b > a) && ((b - a) > half));
    endfunction

    // bit position of s in an ack field headed by ack, may be negative
    function automatic logic signed [17:0] bit_pos(input logic [15:0] s,
                                                   input logic [15:0] ack,
                                                   input logic [15:0] smax);
        logic signed [17:0] r;
        if (s > ack) begin
            r = $signed({2'b00, ack}) + $signed({2'b00, smax}) - $signed({2'b00, s});
        end else begin
            r = $signed({2'b00, ack}) - 18'sd1 - $signed({2'b00, s});
        end
        return r;
    endfunction

    function automatic logic pos_covered(input logic signed [17:0] p);
        return (p[17:5] == 13'd0);
    endfunction

endpackage

// ===== hw/rtl/sak_in_if.sv =====
// request channel carrying one input item
interface sak_in_if;
    logic               valid;
    logic               ready;
    sak_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sak_out_if.sv =====
// result channel carrying one result item
interface sak_out_if;
    logic               valid;
    logic               ready;
    sak_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sak_ram.sv =====
// generic single write, single read ram with registered read
module sak_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/sak_rtt.sv =====
// rtt smoothing unit: rtt += round((age*256 - rtt) / 10)
module sak_rtt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sak_pkg::t_rtt_req i_req,
    input  logic [23:0]       i_rtt,
    output sak_pkg::t_rtt_rsp o_rsp
);
    logic               r_v1;
    logic               r_v2;
    logic               r_neg1;
    logic               r_neg2;
    logic [24:0]        r_mag;
    logic [49:0]        r_prod;
    logic signed [25:0] diff;
    logic [25:0]        mag;
    logic [21:0]        quot;

    always_comb begin
        diff = $signed({2'b00, i_req.age, 8'h00}) - $signed({2'b00, i_rtt});
        mag  = diff[25] ? 26'(-diff) : 26'(diff);
        quot = r_prod[sak_pkg::RTT_SHIFT +: 22];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
        end
        r_mag  <= mag[24:0] + sak_pkg::RTT_ROUND;
        r_neg1 <= diff[25];
        r_prod <= 50'(r_mag) * 50'(sak_pkg::RTT_RECIP);
        r_neg2 <= r_neg1;
    end

    assign o_rsp.done = r_v2;
    assign o_rsp.rtt  = r_neg2 ? (i_rtt - 24'(quot)) : (i_rtt + 24'(quot));
endmodule

// ===== hw/rtl/sequence_ack_reliability_tracker_top.sv =====
// top level of the sequence and ack reliability tracker
// Packet reliability tracker with wrapping sequence numbers. Each request on
// i_req is a send, receive, ack or tick operation; it yields one result on
// o_res, or for an ack one result per newly acknowledged pending packet (one
// if none, at most 33; last marks the final one). A small sequencer walks the
// pending and received queues, each held in a single-port-read ram as a
// circular buffer. A tick ages the pending entries, then prunes old received
// entries and expires timed-out pending ones; an ack waits on the rtt unit
// for each acknowledged packet. i_req.ready is high only when no item is in
// work. Configuration (sequence_max, timeout) must be written through i_cfg_*
// only while idle; the block itself does not enforce this. There is no
// clearing pass after reset.
module sequence_ack_reliability_tracker_top #(
    parameter int unsigned PENDING_DEPTH = sak_pkg::PENDING_DEPTH_DEF,
    parameter int unsigned RECV_DEPTH    = sak_pkg::RECV_DEPTH_DEF,
    parameter int unsigned WINDOW_BACK   = sak_pkg::WINDOW_BACK_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sak_in_if.sink       i_req,
    sak_out_if.source    o_res,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    `include "assert_macros.svh"

    localparam int unsigned PAW  = $clog2(PENDING_DEPTH);
    localparam int unsigned PFW  = $clog2(PENDING_DEPTH + 1);
    localparam int unsigned RAW  = $clog2(RECV_DEPTH);
    localparam int unsigned RFW  = $clog2(RECV_DEPTH + 1);
    localparam int unsigned IW   = (PFW > RFW) ? PFW : RFW;
    localparam int unsigned ACKW = sak_pkg::ACKW;
    localparam int unsigned GAW  = $clog2(sak_pkg::MAX_ACKS);
    localparam logic [15:0] WB   = 16'(WINDOW_BACK);

    typedef enum logic [4:0] {
        S_IDLE, S_SEND, S_RX_RD, S_RX_EX, S_RX_UPD,
        S_AK_RD, S_AK_EX, S_AK_RTT,
        S_TK_RD, S_TK_EX, S_TK_LRD, S_TK_LEX, S_TK_PRD, S_TK_PEX, S_TK_TRD, S_TK_TEX,
        S_AB_RD, S_AB_EX, S_OUT_RD, S_OUT_LD, S_OUT
    } t_state;

    t_state              r_state;
    logic [15:0]         r_smax;
    logic [15:0]         r_tmo;
    logic [15:0]         r_lseq;
    logic [15:0]         r_rseq;
    logic [PAW-1:0]      r_p_head;
    logic [PFW-1:0]      r_p_fill;
    logic [RAW-1:0]      r_r_head;
    logic [RFW-1:0]      r_r_fill;
    logic [31:0]         r_sent;
    logic [31:0]         r_recv;
    logic [31:0]         r_lost;
    logic [31:0]         r_acked;
    logic [23:0]         r_rtt;
    sak_pkg::t_in_item   r_item;
    logic [IW-1:0]       r_idx;
    logic [PFW-1:0]      r_keep;
    logic [ACKW-1:0]     r_n;
    logic [ACKW-1:0]     r_k;
    logic                r_dup;
    logic [31:0]         r_bits;
    logic [15:0]         r_floor;
    logic [15:0]         r_res_lseq;
    sak_pkg::t_out_item  r_out;
    logic                r_out_v;

    // ram ports
    logic                p_we;
    logic [PAW-1:0]      p_waddr;
    logic [31:0]         p_wdata;
    logic [PAW-1:0]      p_raddr;
    logic [31:0]         p_rdata;
    logic                rv_we;
    logic [RAW-1:0]      rv_waddr;
    logic [RAW-1:0]      rv_raddr;
    logic [15:0]         rv_rdata;
    logic                g_we;
    logic [GAW-1:0]      g_raddr;
    logic [15:0]         g_rdata;

    // datapath helpers
    logic [15:0]         p_seq;
    logic [15:0]         p_age;
    logic [16:0]         age_sum;
    logic [15:0]         age_sat;
    logic signed [17:0]  ak_pos;
    logic                ak_hit;
    logic signed [17:0]  ab_pos;
    logic                ab_stop;
    logic [16:0]         lseq_inc;
    logic [15:0]         lseq_next;
    logic                p_full;
    logic                r_full;
    logic [15:0]         floor_new;
    logic                emit_ack;
    sak_pkg::t_rtt_req   rtt_req;
    sak_pkg::t_rtt_rsp   rtt_rsp;

    // position in a circular queue, offset below depth
    function automatic logic [PAW-1:0] p_at(input logic [PAW-1:0] head,
                                            input logic [PFW-1:0] off);
        logic [PFW:0] sum;
        sum = (PFW+1)'(head) + (PFW+1)'(off);
        if (sum >= (PFW+1)'(PENDING_DEPTH)) begin
            sum = sum - (PFW+1)'(PENDING_DEPTH);
        end
        return sum[PAW-1:0];
    endfunction

    function automatic logic [RAW-1:0] r_at(input logic [RAW-1:0] head,
                                            input logic [RFW-1:0] off);
        logic [RFW:0] sum;
        sum = (RFW+1)'(head) + (RFW+1)'(off);
        if (sum >= (RFW+1)'(RECV_DEPTH)) begin
            sum = sum - (RFW+1)'(RECV_DEPTH);
        end
        return sum[RAW-1:0];
    endfunction

    function automatic logic [PAW-1:0] p_inc(input logic [PAW-1:0] head);
        return (head == PAW'(PENDING_DEPTH - 1)) ? '0 : head + PAW'(1);
    endfunction

    function automatic logic [RAW-1:0] r_inc(input logic [RAW-1:0] head);
        return (head == RAW'(RECV_DEPTH - 1)) ? '0 : head + RAW'(1);
    endfunction

    always_comb begin
        p_seq     = p_rdata[31:16];
        p_age     = p_rdata[15:0];
        age_sum   = {1'b0, p_age} + {1'b0, r_item.delta_ticks};
        age_sat   = age_sum[16] ? 16'hFFFF : age_sum[15:0];
        p_full    = (r_p_fill == PFW'(PENDING_DEPTH));
        r_full    = (r_r_fill == RFW'(RECV_DEPTH));
        lseq_inc  = {1'b0, r_lseq} + 17'd1;
        lseq_next = (lseq_inc > {1'b0, r_smax}) ? 16'd0 : lseq_inc[15:0];
        emit_ack  = (r_item.mode == sak_pkg::MODE_ACK) && (r_n != '0);

        // ack match of the pending entry under read
        ak_pos = sak_pkg::bit_pos(p_seq, r_item.ack_sequence, r_smax);
        ak_hit = (r_n < ACKW'(sak_pkg::MAX_ACKS)) &&
                 ((p_seq == r_item.ack_sequence) ||
                  (!sak_pkg::newer(p_seq, r_item.ack_sequence, r_smax) &&
                   sak_pkg::pos_covered(ak_pos) && r_item.ack_field[ak_pos[4:0]]));

        // ack bits walk stops at the first entry at or past the remote sequence
        ab_pos  = sak_pkg::bit_pos(rv_rdata, r_rseq, r_smax);
        ab_stop = (rv_rdata == r_rseq) || sak_pkg::newer(rv_rdata, r_rseq, r_smax);

        // prune floor from the newest received entry
        if (rv_rdata >= WB) begin
            floor_new = rv_rdata - WB;
        end else if (r_smax >= (WB - rv_rdata)) begin
            floor_new = r_smax - (WB - rv_rdata);
        end else begin
            floor_new = 16'd0;
        end
    end

    // ram control
    always_comb begin
        p_we     = 1'b0;
        p_waddr  = p_at(r_p_head, PFW'(r_idx));
        p_wdata  = {p_seq, age_sat};
        p_raddr  = p_at(r_p_head, PFW'(r_idx));
        rv_we    = 1'b0;
        rv_waddr = r_full ? r_r_head : r_at(r_r_head, r_r_fill);
        rv_raddr = r_at(r_r_head, RFW'(r_idx));
        g_we     = 1'b0;
        g_raddr  = GAW'(r_k);
        rtt_req.start = 1'b0;
        rtt_req.age   = p_age;
        case (r_state)
            S_SEND: begin
                p_we    = 1'b1;
                p_waddr = p_full ? r_p_head : p_at(r_p_head, r_p_fill);
                p_wdata = {r_lseq, 16'h0000};
            end
            S_AK_EX: begin
                if (ak_hit) begin
                    g_we          = 1'b1;
                    rtt_req.start = 1'b1;
                end else begin
                    p_we    = 1'b1;
                    p_waddr = p_at(r_p_head, r_keep);
                    p_wdata = p_rdata;
                end
            end
            S_TK_EX: begin
                p_we = 1'b1;
            end
            S_TK_TRD, S_TK_TEX: begin
                p_raddr = r_p_head;
            end
            S_RX_UPD: begin
                rv_we = !r_dup;
            end
            S_TK_LRD: begin
                rv_raddr = r_at(r_r_head, r_r_fill - RFW'(1));
            end
            S_TK_PRD, S_TK_PEX: begin
                rv_raddr = r_r_head;
            end
            default: begin
            end
        endcase
    end

    sak_ram #(.WIDTH(32), .DEPTH(PENDING_DEPTH)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    sak_ram #(.WIDTH(16), .DEPTH(RECV_DEPTH)) u_recv_ram (
        .i_clk   (i_clk),
        .i_we    (rv_we),
        .i_waddr (rv_waddr),
        .i_wdata (r_item.rx_sequence),
        .i_raddr (rv_raddr),
        .o_rdata (rv_rdata)
    );

    // sequences acknowledged by the current ack item, replayed on output
    sak_ram #(.WIDTH(16), .DEPTH(sak_pkg::MAX_ACKS)) u_got_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (GAW'(r_n)),
        .i_wdata (p_seq),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    sak_rtt u_rtt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rtt_req),
        .i_rtt   (r_rtt),
        .o_rsp   (rtt_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_smax   <= sak_pkg::SEQ_MAX_RST;
            r_tmo    <= sak_pkg::TIMEOUT_RST;
            r_lseq   <= '0;
            r_rseq   <= '0;
            r_p_head <= '0;
            r_p_fill <= '0;
            r_r_head <= '0;
            r_r_fill <= '0;
            r_sent   <= '0;
            r_recv   <= '0;
            r_lost   <= '0;
            r_acked  <= '0;
            r_rtt    <= '0;
            r_idx    <= '0;
            r_keep   <= '0;
            r_n      <= '0;
            r_k      <= '0;
            r_dup    <= 1'b0;
            r_bits   <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sak_pkg::CFG_SEQ_MAX: r_smax <= i_cfg_data;
                    sak_pkg::CFG_TIMEOUT: r_tmo  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_item     <= i_req.data;
                        r_idx      <= '0;
                        r_keep     <= '0;
                        r_n        <= '0;
                        r_k        <= '0;
                        r_dup      <= 1'b0;
                        r_bits     <= '0;
                        r_res_lseq <= r_lseq;
                        case (i_req.data.mode)
                            sak_pkg::MODE_SEND: r_state <= S_SEND;
                            sak_pkg::MODE_RECV: begin
                                r_recv  <= r_recv + 32'd1;
                                r_state <= S_RX_RD;
                            end
                            sak_pkg::MODE_ACK:  r_state <= S_AK_RD;
                            default:            r_state <= S_TK_RD;
                        endcase
                    end
                end
                S_SEND: begin
                    // full queue drops its oldest entry as lost
                    if (p_full) begin
                        r_p_head <= p_inc(r_p_head);
                        r_lost   <= r_lost + 32'd1;
                    end else begin
                        r_p_fill <= r_p_fill + PFW'(1);
                    end
                    r_sent  <= r_sent + 32'd1;
                    r_lseq  <= lseq_next;
                    r_idx   <= '0;
                    r_state <= S_AB_RD;
                end
                S_RX_RD: begin
                    r_state <= (r_idx < IW'(r_r_fill)) ? S_RX_EX : S_RX_UPD;
                end
                S_RX_EX: begin
                    if (rv_rdata == r_item.rx_sequence) begin
                        r_dup <= 1'b1;
                    end
                    r_idx   <= r_idx + IW'(1);
                    r_state <= S_RX_RD;
                end
                S_RX_UPD: begin
                    if (!r_dup) begin
                        if (r_full) begin
                            r_r_head <= r_inc(r_r_head);
                        end else begin
                            r_r_fill <= r_r_fill + RFW'(1);
                        end
                        if (sak_pkg::newer(r_item.rx_sequence, r_rseq, r_smax)) begin
                            r_rseq <= r_item.rx_sequence;
                        end
                    end
                    r_idx   <= '0;
                    r_state <= S_AB_RD;
                end
                S_AK_RD: begin
                    if (r_idx < IW'(r_p_fill)) begin
                        r_state <= S_AK_EX;
                    end else begin
                        r_p_fill <= r_keep;
                        r_idx    <= '0;
                        r_state  <= S_AB_RD;
                    end
                end
                S_AK_EX: begin
                    if (ak_hit) begin
                        r_n     <= r_n + ACKW'(1);
                        r_state <= S_AK_RTT;
                    end else begin
                        r_keep  <= r_keep + PFW'(1);
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_AK_RD;
                    end
                end
                S_AK_RTT: begin
                    if (rtt_rsp.done) begin
                        r_rtt   <= rtt_rsp.rtt;
                        r_acked <= r_acked + 32'd1;
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_AK_RD;
                    end
                end
                S_TK_RD: begin
                    if (r_idx < IW'(r_p_fill)) begin
                        r_state <= S_TK_EX;
                    end else if (r_r_fill != '0) begin
                        r_state <= S_TK_LRD;
                    end else begin
                        r_state <= S_TK_TRD;
                    end
                end
                S_TK_EX: begin
                    r_idx   <= r_idx + IW'(1);
                    r_state <= S_TK_RD;
                end
                S_TK_LRD: begin
                    r_state <= S_TK_LEX;
                end
                S_TK_LEX: begin
                    r_floor <= floor_new;
                    r_state <= S_TK_PRD;
                end
                S_TK_PRD: begin
                    r_state <= (r_r_fill != '0) ? S_TK_PEX : S_TK_TRD;
                end
                S_TK_PEX: begin
                    if (!sak_pkg::newer(rv_rdata, r_floor, r_smax)) begin
                        r_r_head <= r_inc(r_r_head);
                        r_r_fill <= r_r_fill - RFW'(1);
                        r_state  <= S_TK_PRD;
                    end else begin
                        r_state  <= S_TK_TRD;
                    end
                end
                S_TK_TRD: begin
                    if (r_p_fill != '0) begin
                        r_state <= S_TK_TEX;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_AB_RD;
                    end
                end
                S_TK_TEX: begin
                    // expire the oldest pending entry past the timeout
                    if (p_age > r_tmo) begin
                        r_p_head <= p_inc(r_p_head);
                        r_p_fill <= r_p_fill - PFW'(1);
                        r_lost   <= r_lost + 32'd1;
                        r_state  <= S_TK_TRD;
                    end else begin
                        r_idx    <= '0;
                        r_state  <= S_AB_RD;
                    end
                end
                S_AB_RD: begin
                    r_state <= (r_idx < IW'(r_r_fill)) ? S_AB_EX : S_OUT_RD;
                end
                S_AB_EX: begin
                    if (ab_stop) begin
                        r_state <= S_OUT_RD;
                    end else begin
                        if (sak_pkg::pos_covered(ab_pos)) begin
                            r_bits[ab_pos[4:0]] <= 1'b1;
                        end
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_AB_RD;
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    r_out.local_seq    <= r_res_lseq;
                    r_out.remote_seq   <= r_rseq;
                    r_out.ack_bits_out <= r_bits;
                    r_out.acked_seq    <= emit_ack ? g_rdata : 16'd0;
                    r_out.acked_valid  <= emit_ack;
                    r_out.last         <= !emit_ack || (r_k == r_n - ACKW'(1));
                    r_out.sent_count   <= r_sent;
                    r_out.recv_count   <= r_recv;
                    r_out.lost_count   <= r_lost;
                    r_out.acked_count  <= r_acked;
                    r_out.rtt_avg      <= r_rtt;
                    r_out_v            <= 1'b1;
                    r_state            <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_out_v <= 1'b0;
                        if (r_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + ACKW'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

    // queue bounds, ack cap, and a request never overlaps a pending result
    `SAK_ASSERT(a_pfill_bound, i_clk, i_rst_n, r_p_fill <= PFW'(PENDING_DEPTH))
    `SAK_ASSERT(a_rfill_bound, i_clk, i_rst_n, r_r_fill <= RFW'(RECV_DEPTH))
    `SAK_ASSERT(a_ack_cap, i_clk, i_rst_n, r_n <= ACKW'(sak_pkg::MAX_ACKS))
    `SAK_ASSERT(a_no_overlap, i_clk, i_rst_n, !(i_req.ready && o_res.valid))
    `SAK_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, o_res.valid && o_res.ready && o_res.data.last, i_req.ready)
endmodule
